### rtl/i2c_bus_recovery_sequencer_assert.svh
// Assertion macros for the I2C bus recovery sequencer checker.
// Depends on nothing; included by the checker file.
`ifndef I2C_BUS_RECOVERY_SEQUENCER_ASSERT_SVH
`define I2C_BUS_RECOVERY_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/i2cbr_pkg.sv
// Shared types and constants for the I2C bus recovery sequencer.
// No dependencies.
package i2cbr_pkg;

  localparam int HALF_W   = 16;
  localparam int TIMER_W  = 20;
  localparam int PIDX_W   = 4;
  localparam int OUTC_W   = 3;
  localparam int PHASE_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam int PULSE_COUNT_DEF = 9;

  localparam logic [HALF_W-1:0]  HALF_RST    = 16'd5;
  localparam logic [TIMER_W-1:0] STRETCH_RST = 20'd500000;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH = 1'd1;

  localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SETTLE     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PRE        = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LOW        = 3'd3;
  localparam logic [PHASE_W-1:0] PH_HIGH       = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STRETCH    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_SDA_WAIT   = 3'd6;
  localparam logic [PHASE_W-1:0] PH_START_HOLD = 3'd7;

  localparam logic [OUTC_W-1:0] OUT_NONE      = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_OK        = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_SCL_START = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_SCL_PULSE = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_SDA       = 3'd4;

  typedef struct packed {
    logic [HALF_W-1:0]  half_period_ticks;
    logic [TIMER_W-1:0] stretch_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              scl_pull_low;
    logic              sda_pull_low;
    logic              busy_res;
    logic              finished;
    logic [OUTC_W-1:0] outcome;
  } result_t;

endpackage

### rtl/i2cbr_core.sv
// Recovery state machine: phase, tick timer, pulse counter and line drives.
// Depends on i2cbr_pkg. Advances one tick per step and reports the new state.
module i2cbr_core #(
  parameter int PULSE_COUNT = i2cbr_pkg::PULSE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                start_request,
  input  logic                scl_level,
  input  logic                sda_level,
  input  i2cbr_pkg::cfg_t     cfg,
  output i2cbr_pkg::result_t  res
);

  localparam logic [i2cbr_pkg::PIDX_W-1:0] PulseCnt = i2cbr_pkg::PIDX_W'(PULSE_COUNT);

  logic [i2cbr_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [i2cbr_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic [i2cbr_pkg::PIDX_W-1:0]  pidx_r, pidx_nxt;
  logic                          scl_r, scl_nxt;
  logic                          sda_r, sda_nxt;
  logic [i2cbr_pkg::OUTC_W-1:0]  outc_r, outc_nxt;
  logic                          done;

  logic [i2cbr_pkg::HALF_W-1:0]  half_eff;
  logic [i2cbr_pkg::TIMER_W-1:0] t_inc;
  logic [i2cbr_pkg::PIDX_W-1:0]  pidx_inc;
  logic                          half_done;
  logic                          stretch_out;

  assign half_eff  = (cfg.half_period_ticks == '0) ? i2cbr_pkg::HALF_W'(1)
                                                   : cfg.half_period_ticks;
  assign t_inc     = timer_r + i2cbr_pkg::TIMER_W'(1);
  assign pidx_inc  = pidx_r + i2cbr_pkg::PIDX_W'(1);
  assign half_done = t_inc >= i2cbr_pkg::TIMER_W'(half_eff);
  assign stretch_out = t_inc >= cfg.stretch_timeout_ticks;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    pidx_nxt  = pidx_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    outc_nxt  = outc_r;
    done      = 1'b0;
    case (phase_r)
      i2cbr_pkg::PH_SETTLE: begin
        timer_nxt = half_done ? '0 : t_inc;
        if (half_done) begin
          if (!scl_level) begin
            done     = 1'b1;
            outc_nxt = i2cbr_pkg::OUT_SCL_START;
          end else begin
            phase_nxt = i2cbr_pkg::PH_PRE;
          end
        end
      end
      i2cbr_pkg::PH_PRE: begin
        timer_nxt = half_done ? '0 : t_inc;
        if (half_done) begin
          scl_nxt   = 1'b1;
          pidx_nxt  = '0;
          phase_nxt = i2cbr_pkg::PH_LOW;
        end
      end
      i2cbr_pkg::PH_LOW: begin
        timer_nxt = half_done ? '0 : t_inc;
        if (half_done) begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cbr_pkg::PH_HIGH;
        end
      end
      i2cbr_pkg::PH_HIGH, i2cbr_pkg::PH_STRETCH: begin
        if (phase_r == i2cbr_pkg::PH_HIGH) begin
          timer_nxt = half_done ? '0 : t_inc;
        end
        if (phase_r == i2cbr_pkg::PH_STRETCH || half_done) begin
          if (scl_level) begin
            timer_nxt = '0;
            pidx_nxt  = pidx_inc;
            if (pidx_inc < PulseCnt) begin
              scl_nxt   = 1'b1;
              phase_nxt = i2cbr_pkg::PH_LOW;
            end else if (!sda_level) begin
              done     = 1'b1;
              outc_nxt = i2cbr_pkg::OUT_SDA;
            end else begin
              phase_nxt = i2cbr_pkg::PH_SDA_WAIT;
            end
          end else if (phase_r == i2cbr_pkg::PH_HIGH) begin
            if (cfg.stretch_timeout_ticks == '0) begin
              done     = 1'b1;
              outc_nxt = i2cbr_pkg::OUT_SCL_PULSE;
            end else begin
              phase_nxt = i2cbr_pkg::PH_STRETCH;
            end
          end else if (stretch_out) begin
            done     = 1'b1;
            outc_nxt = i2cbr_pkg::OUT_SCL_PULSE;
          end else begin
            timer_nxt = t_inc;
          end
        end
      end
      i2cbr_pkg::PH_SDA_WAIT: begin
        timer_nxt = half_done ? '0 : t_inc;
        if (half_done) begin
          sda_nxt   = 1'b1;
          phase_nxt = i2cbr_pkg::PH_START_HOLD;
        end
      end
      i2cbr_pkg::PH_START_HOLD: begin
        timer_nxt = half_done ? '0 : t_inc;
        if (half_done) begin
          done     = 1'b1;
          outc_nxt = i2cbr_pkg::OUT_OK;
        end
      end
      default: begin
        phase_nxt = i2cbr_pkg::PH_IDLE;
        timer_nxt = '0;
        pidx_nxt  = '0;
        scl_nxt   = 1'b0;
        sda_nxt   = 1'b0;
        if (start_request) begin
          phase_nxt = i2cbr_pkg::PH_SETTLE;
          outc_nxt  = i2cbr_pkg::OUT_NONE;
        end
      end
    endcase
    if (done) begin
      phase_nxt = i2cbr_pkg::PH_IDLE;
      timer_nxt = '0;
      pidx_nxt  = '0;
      scl_nxt   = 1'b0;
      sda_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cbr_pkg::PH_IDLE;
      timer_r <= '0;
      pidx_r  <= '0;
      scl_r   <= 1'b0;
      sda_r   <= 1'b0;
      outc_r  <= i2cbr_pkg::OUT_NONE;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      pidx_r  <= pidx_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      outc_r  <= outc_nxt;
    end
  end

  always_comb begin
    res.scl_pull_low = scl_nxt;
    res.sda_pull_low = sda_nxt;
    res.busy_res     = phase_nxt != i2cbr_pkg::PH_IDLE;
    res.finished     = done;
    res.outcome      = outc_nxt;
  end

endmodule

### rtl/i2c_bus_recovery_sequencer.sv
// I2C bus-clear sequencer top level: configuration, handshake and result buffer.
// Depends on i2cbr_pkg and i2cbr_core.
//
// Each input beat is one timing tick carrying start_request and the sampled
// SCL and SDA levels. Every accepted beat yields exactly one result beat with
// the open-drain drives, busy, the one-tick finished flag and the outcome.
// An accepted beat's result is registered in the result register, or in the
// skid entry while a result waits. One beat per cycle while in_stall is low;
// the state machine update is one combinational step from the state registers
// to the result register. A result register plus one skid entry let the block
// take a new beat while a result waits; in_stall rises only when the skid
// entry is occupied, and drops the cycle after the receiver takes a beat.
// Reset (rst_n low, synchronous) returns to idle with both lines released,
// outcome cleared, half period 5 ticks and stretch timeout 500000 ticks.
// Write cfg_data to register cfg_index with cfg_wr_en only while idle.
module i2c_bus_recovery_sequencer #(
  parameter int PULSE_COUNT = i2cbr_pkg::PULSE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_start_request,
  input  logic                                in_scl_level,
  input  logic                                in_sda_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_scl_pull_low,
  output logic                                out_sda_pull_low,
  output logic                                out_busy_res,
  output logic                                out_finished,
  output logic [i2cbr_pkg::OUTC_W-1:0]        out_outcome,
  input  logic                                cfg_wr_en,
  input  logic [i2cbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2cbr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  i2cbr_pkg::cfg_t    cfg_r;
  i2cbr_pkg::result_t res;
  i2cbr_pkg::result_t out_r;
  i2cbr_pkg::result_t skid_r;
  logic               out_valid_r;
  logic               skid_valid_r;
  logic               accept;
  logic               out_fire;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks     <= i2cbr_pkg::HALF_RST;
      cfg_r.stretch_timeout_ticks <= i2cbr_pkg::STRETCH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        i2cbr_pkg::CFG_HALF:
          cfg_r.half_period_ticks <= cfg_data[i2cbr_pkg::HALF_W-1:0];
        i2cbr_pkg::CFG_STRETCH:
          cfg_r.stretch_timeout_ticks <= cfg_data[i2cbr_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  i2cbr_core #(
    .PULSE_COUNT (PULSE_COUNT)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (accept),
    .start_request (in_start_request),
    .scl_level     (in_scl_level),
    .sda_level     (in_sda_level),
    .cfg           (cfg_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_pull_low = out_r.scl_pull_low;
  assign out_sda_pull_low = out_r.sda_pull_low;
  assign out_busy_res     = out_r.busy_res;
  assign out_finished     = out_r.finished;
  assign out_outcome      = out_r.outcome;

endmodule

### rtl/i2cbr_checker.sv
// Port-level checker for the I2C bus recovery sequencer, bound to the top level.
// Depends on i2cbr_pkg and i2c_bus_recovery_sequencer_assert.svh.
`include "i2c_bus_recovery_sequencer_assert.svh"

module i2cbr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_busy_res,
  input logic                         out_finished,
  input logic [i2cbr_pkg::OUTC_W-1:0] out_outcome
);

  `I2CBR_ASSERT_NEXT(a_beat_yields_result, clk, rst_n, in_valid && !in_stall, out_valid, "accepted beat produced no result")
  `I2CBR_ASSERT_NEXT(a_stalled_result_holds, clk, rst_n, out_valid && out_stall, out_valid, "stalled result dropped")
  `I2CBR_ASSERT_NOW(a_finish_not_busy, clk, rst_n, out_valid && out_finished, !out_busy_res && out_outcome != i2cbr_pkg::OUT_NONE, "finish beat busy or without outcome")
  `I2CBR_ASSERT_NOW(a_outcome_range, clk, rst_n, out_valid, out_outcome <= i2cbr_pkg::OUT_SDA, "outcome code out of range")

endmodule

bind i2c_bus_recovery_sequencer i2cbr_checker u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_busy_res (out_busy_res),
  .out_finished (out_finished),
  .out_outcome  (out_outcome)
);

### tb/i2c_bus_recovery_sequencer_tb.sv
// Testbench for the I2C bus recovery sequencer: drives timing ticks with line levels,
// predicts every result beat in a behavioral model and compares field by field.
// Depends on i2cbr_pkg and i2c_bus_recovery_sequencer.
`timescale 1ns / 1ps

module i2c_bus_recovery_sequencer_tb;
  import i2cbr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_start_request = 1'b0;
  logic in_scl_level = 1'b0;
  logic in_sda_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_scl_pull_low;
  logic out_sda_pull_low;
  logic out_busy_res;
  logic out_finished;
  logic [OUTC_W-1:0] out_outcome;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // sequencer model state and its copy of the registers
  logic [PHASE_W-1:0] bus_phase = PH_IDLE;
  logic [TIMER_W-1:0] bus_timer = '0;
  logic [PIDX_W-1:0] pulse_cnt = '0;
  logic scl_hold = 1'b0;
  logic sda_hold = 1'b0;
  logic [OUTC_W-1:0] last_code = OUT_NONE;
  logic seq_done = 1'b0;
  logic [HALF_W-1:0] half_cfg = HALF_RST;
  logic [TIMER_W-1:0] stretch_cfg = STRETCH_RST;

  result_t expected_drives[$];
  result_t want_beat;

  int mismatch_count = 0;
  int beats_checked = 0;
  int active_ticks = 0;
  int items_sent = 0;
  int ends_by_code[0:7];
  int send_gap_pct = 37;
  int stall_pct = 37;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  i2c_bus_recovery_sequencer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_request(in_start_request),
    .in_scl_level(in_scl_level),
    .in_sda_level(in_sda_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_scl_pull_low(out_scl_pull_low),
    .out_sda_pull_low(out_sda_pull_low),
    .out_busy_res(out_busy_res),
    .out_finished(out_finished),
    .out_outcome(out_outcome),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int half_limit();
    return (half_cfg == '0) ? 1 : int'(half_cfg);
  endfunction

  function automatic bit half_tick();
    int nxt;
    nxt = int'(bus_timer) + 1;
    if (nxt >= half_limit()) begin
      bus_timer = '0;
      return 1'b1;
    end
    bus_timer = nxt[TIMER_W-1:0];
    return 1'b0;
  endfunction

  task automatic end_seq(input logic [OUTC_W-1:0] code);
    bus_phase = PH_IDLE;
    bus_timer = '0;
    pulse_cnt = '0;
    scl_hold = 1'b0;
    sda_hold = 1'b0;
    last_code = code;
    seq_done = 1'b1;
  endtask

  task automatic next_pulse(input bit sda);
    bus_timer = '0;
    pulse_cnt = pulse_cnt + 1'b1;
    if (pulse_cnt < PULSE_COUNT_DEF) begin
      scl_hold = 1'b1;
      bus_phase = PH_LOW;
    end else if (!sda) begin
      end_seq(OUT_SDA);
    end else begin
      bus_phase = PH_SDA_WAIT;
    end
  endtask

  task automatic predict_tick(input bit start, input bit scl, input bit sda,
                              output result_t r);
    logic [TIMER_W-1:0] nxt;
    seq_done = 1'b0;
    case (bus_phase)
      PH_SETTLE: if (half_tick()) begin
        if (!scl)
          end_seq(OUT_SCL_START);
        else
          bus_phase = PH_PRE;
      end
      PH_PRE: if (half_tick()) begin
        scl_hold = 1'b1;
        pulse_cnt = '0;
        bus_phase = PH_LOW;
      end
      PH_LOW: if (half_tick()) begin
        scl_hold = 1'b0;
        bus_phase = PH_HIGH;
      end
      PH_HIGH: if (half_tick()) begin
        if (scl)
          next_pulse(sda);
        else if (stretch_cfg == '0)
          end_seq(OUT_SCL_PULSE);
        else
          bus_phase = PH_STRETCH;
      end
      PH_STRETCH: begin
        if (scl) begin
          next_pulse(sda);
        end else begin
          nxt = bus_timer + 1'b1;
          if (nxt >= stretch_cfg)
            end_seq(OUT_SCL_PULSE);
          else
            bus_timer = nxt;
        end
      end
      PH_SDA_WAIT: if (half_tick()) begin
        sda_hold = 1'b1;
        bus_phase = PH_START_HOLD;
      end
      PH_START_HOLD: if (half_tick()) begin
        end_seq(OUT_OK);
      end
      default: begin
        bus_phase = PH_IDLE;
        bus_timer = '0;
        pulse_cnt = '0;
        scl_hold = 1'b0;
        sda_hold = 1'b0;
        if (start) begin
          bus_phase = PH_SETTLE;
          last_code = OUT_NONE;
        end
      end
    endcase
    r.scl_pull_low = scl_hold;
    r.sda_pull_low = sda_hold;
    r.busy_res = (bus_phase != PH_IDLE);
    r.finished = seq_done;
    r.outcome = last_code;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [OUTC_W-1:0] got,
                             input logic [OUTC_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %0d want %0d", beats_checked, name, got, want));
  endtask

  // hold off the result side: a burst on request, otherwise random
  always @(posedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= 60;
      out_stall <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_drives.size() == 0) begin
        report_mismatch("result beat with no tick outstanding");
      end else begin
        want_beat = expected_drives.pop_front();
        check_field("scl_pull_low", OUTC_W'(out_scl_pull_low),
                    OUTC_W'(want_beat.scl_pull_low));
        check_field("sda_pull_low", OUTC_W'(out_sda_pull_low),
                    OUTC_W'(want_beat.sda_pull_low));
        check_field("busy_res", OUTC_W'(out_busy_res), OUTC_W'(want_beat.busy_res));
        check_field("finished", OUTC_W'(out_finished), OUTC_W'(want_beat.finished));
        check_field("outcome", out_outcome, want_beat.outcome);
        if (want_beat.finished)
          ends_by_code[want_beat.outcome]++;
      end
      beats_checked++;
    end
  end

  task automatic send_tick(input bit start, input bit scl, input bit sda);
    result_t r;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_start_request <= start;
    in_scl_level <= scl;
    in_sda_level <= sda;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (start || bus_phase != PH_IDLE)
      active_ticks++;
    predict_tick(start, scl, sda, r);
    expected_drives.push_back(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_drives.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_HALF)
      half_cfg = val[HALF_W-1:0];
    else
      stretch_cfg = val;
  endtask

  // drive one recovery from idle with a well-behaved bus, optionally faulted
  task automatic run_recovery(input bit scl_stuck, input int max_stretch, input bit sda_stuck);
    int low_left;
    bit scl_bit;
    bit sda_bit;
    low_left = 0;
    send_tick(1'b1, 1'($urandom), 1'($urandom));
    while (bus_phase != PH_IDLE) begin
      scl_bit = 1'($urandom);
      sda_bit = 1'($urandom);
      case (bus_phase)
        PH_SETTLE: scl_bit = !scl_stuck;
        PH_LOW: low_left = $urandom_range(0, max_stretch);
        PH_HIGH, PH_STRETCH: begin
          scl_bit = (low_left == 0);
          if (pulse_cnt == PULSE_COUNT_DEF - 1)
            sda_bit = !sda_stuck;
          if (!scl_bit && (bus_phase == PH_STRETCH || int'(bus_timer) + 1 >= half_limit()))
            low_left--;
        end
        default: ;
      endcase
      send_tick(1'($urandom), scl_bit, sda_bit);
    end
  endtask

  task automatic settle_random();
    while (bus_phase != PH_IDLE)
      send_tick(1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_reset_defaults();
    repeat (4) send_tick(1'b0, 1'($urandom), 1'($urandom));
    run_recovery(1'b0, 3, 1'b0);
  endtask

  task automatic test_line_faults();
    run_recovery(1'b1, 0, 1'b0);
    run_recovery(1'b0, 0, 1'b1);
    run_recovery(1'b0, 2, 1'b0);
  endtask

  task automatic test_stretch_limits();
    write_reg(CFG_HALF, 20'd1);
    write_reg(CFG_STRETCH, 20'd0);
    run_recovery(1'b0, 2, 1'b0);
    write_reg(CFG_STRETCH, 20'd3);
    run_recovery(1'b0, 6, 1'b0);
    write_reg(CFG_STRETCH, 20'hFFFFF);
    run_recovery(1'b0, 25, 1'b0);
  endtask

  task automatic test_half_period_extremes();
    write_reg(CFG_HALF, 20'd0);
    run_recovery(1'b0, 1, 1'b0);
    write_reg(CFG_HALF, 20'hF0040);
    run_recovery(1'b1, 0, 1'b0);
    write_reg(CFG_HALF, 20'd1);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_STRETCH, 20'd2);
    send_gap_pct = 0;
    holdoff_req++;
    run_recovery(1'b0, 2, 1'b0);
    wait_drained();
    send_gap_pct = 37;
    run_recovery(1'b0, 2, 1'b0);
  endtask

  task automatic test_no_idle();
    send_gap_pct = 0;
    stall_pct = 0;
    run_recovery(1'b0, 3, 1'b0);
    run_recovery(1'b0, 3, 1'b1);
    send_gap_pct = 37;
    stall_pct = 37;
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [3:0] junk;
    logic [TIMER_W-1:0] val;
    while (items_sent < 1250) begin
      if ($urandom_range(0, 3) == 0) begin
        junk = 4'($urandom);
        val = ($urandom_range(0, 5) == 0) ? 20'd0 : TIMER_W'($urandom_range(1, 4));
        write_reg(CFG_HALF, {junk, val[HALF_W-1:0]});
        case ($urandom_range(0, 4))
          0: val = 20'd0;
          1: val = 20'd1;
          2: val = TIMER_W'($urandom_range(2, 8));
          3: val = STRETCH_RST;
          default: val = 20'hFFFFF;
        endcase
        write_reg(CFG_STRETCH, val);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_recovery($urandom_range(0, 9) == 0, $urandom_range(0, 5), $urandom_range(0, 6) == 0);
      end else if (pick < 85) begin
        repeat ($urandom_range(3, 30))
          send_tick($urandom_range(0, 4) == 0, 1'($urandom), 1'($urandom));
        settle_random();
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(1'b0, 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_line_faults();
    test_stretch_limits();
    test_half_period_extremes();
    test_backpressure();
    test_no_idle();
    test_random_traffic();
    in_valid <= 1'b0;
    for (int i = 0; i < 10000 && expected_drives.size() != 0; i++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_drives.size() != 0)
      report_mismatch($sformatf("%0d ticks never produced a result", expected_drives.size()));
    $display("covered %0d result beats from %0d ticks (%0d active), half periods 0..4 and 64,",
             beats_checked, items_sent, active_ticks);
    $display("stretch 0..1048575; ends: %0d recovered, %0d scl start, %0d scl pulse, %0d sda",
             ends_by_code[OUT_OK], ends_by_code[OUT_SCL_START], ends_by_code[OUT_SCL_PULSE],
             ends_by_code[OUT_SDA]);
    if (mismatch_count == 0) begin
      $display("i2c_bus_recovery_sequencer_tb passed");
    end else begin
      $display("i2c_bus_recovery_sequencer_tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_drives.size());
    $display("i2c_bus_recovery_sequencer_tb failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/i2cbr_pkg.sv
rtl/i2cbr_core.sv
rtl/i2c_bus_recovery_sequencer.sv
rtl/i2cbr_checker.sv
tb/i2c_bus_recovery_sequencer_tb.sv
